FILE: hdl/tape_machine_interpreter_defines.svh
// Assertion macros shared by the tape machine interpreter RTL.
`ifndef TAPE_MACHINE_INTERPRETER_DEFINES_SVH
`define TAPE_MACHINE_INTERPRETER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TMI_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TMI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tmi_pkg.sv
// Types and constants of the tape machine interpreter.
package tmi_pkg;

  localparam int unsigned CELL_W      = 8;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned PROG_ADDR_W = 12;
  localparam int unsigned S_TDATA_W   = 24;
  localparam int unsigned S_TUSER_W   = 2;
  localparam int unsigned M_TDATA_W   = 16;
  localparam int unsigned M_TUSER_W   = 2;

  typedef enum logic [2:0] {
    OP_LEFT  = 3'd0,
    OP_RIGHT = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_STEP    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_WAIT      = 2'd1,
    STATUS_HALT      = 2'd2,
    STATUS_UNMATCHED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] data;
  } tape_wr_t;

  typedef struct packed {
    logic en;
    op_e  op;
  } prog_wr_t;

endpackage

FILE: hdl/tmi_prog.sv
// Program store: one write port for loads, one registered read port.
module tmi_prog #(
  parameter int unsigned PROGRAM_DEPTH = 4096,
  parameter int unsigned AddrW         = $clog2(PROGRAM_DEPTH)
) (
  input  logic             clk_i,
  input  tmi_pkg::prog_wr_t wr_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output tmi_pkg::op_e     rd_op_o
);
  import tmi_pkg::*;

  op_e mem [PROGRAM_DEPTH];
  op_e rd_op_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr_i] <= wr_i.op;
    end
    rd_op_q <= mem[rd_addr_i];
  end

  assign rd_op_o = rd_op_q;

endmodule

FILE: hdl/tmi_tape.sv
// Tape memory with a registered read port and a zero-fill sweep after reset or restart.
module tmi_tape #(
  parameter int unsigned TAPE_CELLS = 32768,
  parameter int unsigned HeadW      = $clog2(TAPE_CELLS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_start_i,
  output logic                      busy_o,
  input  logic [HeadW-1:0]          rd_addr_i,
  output logic [tmi_pkg::CELL_W-1:0] rd_data_o,
  input  logic [HeadW-1:0]          wr_addr_i,
  input  tmi_pkg::tape_wr_t         wr_i
);
  import tmi_pkg::*;

  localparam logic [HeadW-1:0] LastCell = HeadW'(TAPE_CELLS - 1);

  logic [CELL_W-1:0] mem [TAPE_CELLS];
  logic [CELL_W-1:0] rd_data_q;
  logic              busy_q, busy_d;
  logic [HeadW-1:0]  clr_cnt_q, clr_cnt_d;

  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_start_i) begin
      busy_d    = 1'b1;
      clr_cnt_d = '0;
    end else if (busy_q) begin
      clr_cnt_d = clr_cnt_q + HeadW'(1);
      if (clr_cnt_q == LastCell) begin
        busy_d = 1'b0;
      end
    end
  end

  // Start sweeping out of reset so the tape reads as zeros.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_i.en) begin
      mem[wr_addr_i] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign busy_o    = busy_q;
  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/tape_machine_interpreter.sv
// Tape machine interpreter top level: request decode, execution, bracket scan, result register.
//
// Items arrive on the s_axis side and each gives one result on the m_axis side, held in an
// output register so a new request is taken while a result waits. The program counter and
// head address both memories at once, so a load, a restart or a plain step is accepted in
// ST_IDLE, where the program store and the tape are read, and executes in ST_EXEC, writing
// the cell back once the result register is free. A due bracket jump walks the program
// store one entry per cycle through its single read port, up to the matching bracket (or
// to the program end or start when none matches). After reset and after each restart the
// tape is zero-filled at one cell per cycle, and no request is taken until the fill is
// done; the configuration write channel is always ready.
`include "tape_machine_interpreter_defines.svh"

module tape_machine_interpreter #(
  parameter int unsigned TAPE_CELLS    = 32768,
  parameter int unsigned PROGRAM_DEPTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: prog_addr[11:0], opcode[14:12], in_byte[22:15], in_valid[23]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tmi_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [tmi_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // tdata: out_byte[7:0], out_valid[8], in_taken[9], zeros above
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tmi_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [tmi_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmi_pkg::LEN_W-1:0]     cfg_data_i
);
  import tmi_pkg::*;

  localparam int unsigned PcW   = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(PROGRAM_DEPTH);
  localparam int unsigned HeadW = $clog2(TAPE_CELLS);
  localparam logic [HeadW-1:0] HeadLast = HeadW'(TAPE_CELLS - 1);

  state_e state_q, state_d;

  logic [LEN_W-1:0] len_q;
  logic [PcW-1:0]   eff_len;

  // Request held for the execute cycle.
  func_e                  func_q;
  logic [PROG_ADDR_W-1:0] addr_q;
  op_e                    opcode_q;
  logic [CELL_W-1:0]      in_byte_q;
  logic                   in_valid_q;

  logic [PcW-1:0]   pc_q, pc_d;
  logic [HeadW-1:0] head_q, head_d;

  // Bracket scan.
  logic [PcW-1:0] ptr_q, ptr_d;
  logic [PcW-1:0] chk_q, chk_d;
  logic           vld_q, vld_d;
  logic           fwd_q, fwd_d;
  logic [PcW-1:0] depth_q, depth_d;
  status_e        resp_q, resp_d;
  logic           scan_deeper, scan_closes, scan_end_fwd, scan_hit, scan_miss;

  // Result register.
  logic              m_valid_q, m_valid_d;
  logic [CELL_W-1:0] obyte_q, obyte_d;
  logic              obvalid_q, obvalid_d;
  status_e           ostatus_q, ostatus_d;
  logic              otaken_q, otaken_d;
  logic              out_free;

  // Execute decode.
  logic              ex_emit, ex_cell_we, ex_bvalid, ex_taken;
  logic              ex_scan, ex_fwd, ex_clear, ex_load;
  logic [PcW-1:0]    ex_pc;
  logic [HeadW-1:0]  ex_head;
  logic [CELL_W-1:0] ex_cell_wd, ex_byte;
  status_e           ex_status;

  // Memory ports.
  op_e               prog_op;
  prog_wr_t          prog_wr;
  logic [AddrW-1:0]  prog_rd_addr;
  logic [CELL_W-1:0] cell_rd;
  tape_wr_t          tape_wr;
  logic              tape_busy;
  logic              clr_start;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    if (32'(len_q) >= PROGRAM_DEPTH) begin
      eff_len = PcW'(PROGRAM_DEPTH);
    end else begin
      eff_len = PcW'(len_q);
    end
  end

  assign prog_rd_addr = (state_q == ST_SCAN) ? ptr_q[AddrW-1:0] : pc_q[AddrW-1:0];

  tmi_prog #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH),
    .AddrW        (AddrW)
  ) u_prog (
    .clk_i    (clk_i),
    .wr_i     (prog_wr),
    .wr_addr_i(AddrW'(addr_q)),
    .rd_addr_i(prog_rd_addr),
    .rd_op_o  (prog_op)
  );

  tmi_tape #(
    .TAPE_CELLS(TAPE_CELLS),
    .HeadW     (HeadW)
  ) u_tape (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_start_i(clr_start),
    .busy_o     (tape_busy),
    .rd_addr_i  (head_q),
    .rd_data_o  (cell_rd),
    .wr_addr_i  (head_q),
    .wr_i       (tape_wr)
  );

  // Decode one request against the program entry and cell read at acceptance.
  always_comb begin
    ex_emit    = 1'b1;
    ex_pc      = pc_q;
    ex_head    = head_q;
    ex_cell_we = 1'b0;
    ex_cell_wd = cell_rd;
    ex_status  = STATUS_OK;
    ex_byte    = '0;
    ex_bvalid  = 1'b0;
    ex_taken   = 1'b0;
    ex_scan    = 1'b0;
    ex_fwd     = 1'b0;
    ex_clear   = 1'b0;
    ex_load    = 1'b0;
    case (func_q)
      FUNC_LOAD: begin
        ex_load = (32'(addr_q) < PROGRAM_DEPTH);
      end
      FUNC_RESTART: begin
        ex_clear = 1'b1;
        ex_pc    = '0;
        ex_head  = '0;
      end
      FUNC_STEP: begin
        if (pc_q >= eff_len) begin
          ex_status = STATUS_HALT;
        end else begin
          ex_pc = pc_q + PcW'(1);
          case (prog_op)
            OP_LEFT: begin
              ex_head = (head_q == '0) ? HeadLast : head_q - HeadW'(1);
            end
            OP_RIGHT: begin
              ex_head = (head_q == HeadLast) ? '0 : head_q + HeadW'(1);
            end
            OP_INC: begin
              ex_cell_we = 1'b1;
              ex_cell_wd = cell_rd + CELL_W'(1);
            end
            OP_DEC: begin
              ex_cell_we = 1'b1;
              ex_cell_wd = cell_rd - CELL_W'(1);
            end
            OP_OUT: begin
              ex_byte   = cell_rd;
              ex_bvalid = 1'b1;
            end
            OP_IN: begin
              if (in_valid_q) begin
                ex_cell_we = 1'b1;
                ex_cell_wd = in_byte_q;
                ex_taken   = 1'b1;
              end else begin
                ex_status = STATUS_WAIT;
                ex_pc     = pc_q;
              end
            end
            OP_OPEN: begin
              if (cell_rd == '0) begin
                ex_pc   = pc_q;
                ex_emit = 1'b0;
                ex_scan = 1'b1;
                ex_fwd  = 1'b1;
              end
            end
            OP_CLOSE: begin
              if (cell_rd != '0) begin
                ex_pc = pc_q;
                if (pc_q == '0) begin
                  ex_status = STATUS_UNMATCHED;
                end else begin
                  ex_emit = 1'b0;
                  ex_scan = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Scan step: the entry at chk_q is in prog_op when vld_q is set.
  always_comb begin
    scan_deeper  = fwd_q ? (prog_op == OP_OPEN) : (prog_op == OP_CLOSE);
    scan_closes  = fwd_q ? (prog_op == OP_CLOSE) : (prog_op == OP_OPEN);
    scan_end_fwd = fwd_q && (chk_q >= eff_len);
    scan_hit     = vld_q && !scan_end_fwd && scan_closes && (depth_q == PcW'(1));
    scan_miss    = vld_q && (scan_end_fwd || (!fwd_q && !scan_hit && chk_q == '0));
  end

  // Commit only when the result register can take the result, else hold and re-read.
  assign prog_wr.en    = (state_q == ST_EXEC) && ex_load && out_free;
  assign prog_wr.op    = opcode_q;
  assign tape_wr.en    = (state_q == ST_EXEC) && ex_cell_we && out_free;
  assign tape_wr.data  = ex_cell_wd;
  assign clr_start     = (state_q == ST_EXEC) && ex_clear && out_free;

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    head_d    = head_q;
    ptr_d     = ptr_q;
    chk_d     = chk_q;
    vld_d     = 1'b0;
    fwd_d     = fwd_q;
    depth_d   = depth_q;
    resp_d    = resp_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    obyte_d   = obyte_q;
    obvalid_d = obvalid_q;
    ostatus_d = ostatus_q;
    otaken_d  = otaken_q;
    case (state_q)
      ST_CLEAR: begin
        if (!tape_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ex_scan) begin
          ptr_d   = ex_fwd ? pc_q + PcW'(1) : pc_q - PcW'(1);
          depth_d = PcW'(1);
          fwd_d   = ex_fwd;
          state_d = ST_SCAN;
        end else if (ex_emit && out_free) begin
          pc_d      = ex_pc;
          head_d    = ex_head;
          m_valid_d = 1'b1;
          obyte_d   = ex_byte;
          obvalid_d = ex_bvalid;
          ostatus_d = ex_status;
          otaken_d  = ex_taken;
          state_d   = ex_clear ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_SCAN: begin
        ptr_d = fwd_q ? ptr_q + PcW'(1) : ptr_q - PcW'(1);
        chk_d = ptr_q;
        vld_d = 1'b1;
        if (scan_hit) begin
          pc_d    = chk_q + PcW'(1);
          resp_d  = STATUS_OK;
          state_d = ST_RESP;
        end else if (scan_miss) begin
          resp_d  = STATUS_UNMATCHED;
          state_d = ST_RESP;
        end else if (vld_q) begin
          if (scan_deeper) begin
            depth_d = depth_q + PcW'(1);
          end else if (scan_closes) begin
            depth_d = depth_q - PcW'(1);
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          obyte_d   = '0;
          obvalid_d = 1'b0;
          ostatus_d = resp_q;
          otaken_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      len_q     <= '0;
      pc_q      <= '0;
      head_q    <= '0;
      vld_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      head_q    <= head_d;
      vld_q     <= vld_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q     <= func_e'(s_axis_tuser[1:0]);
      addr_q     <= s_axis_tdata[11:0];
      opcode_q   <= op_e'(s_axis_tdata[14:12]);
      in_byte_q  <= s_axis_tdata[22:15];
      in_valid_q <= s_axis_tdata[23];
    end
    ptr_q     <= ptr_d;
    chk_q     <= chk_d;
    fwd_q     <= fwd_d;
    depth_q   <= depth_d;
    resp_q    <= resp_d;
    obyte_q   <= obyte_d;
    obvalid_q <= obvalid_d;
    ostatus_q <= ostatus_d;
    otaken_q  <= otaken_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, otaken_q, obvalid_q, obyte_q};
  assign m_axis_tuser  = ostatus_q;

  `TMI_ASSERT_NEXT(a_accept_exec, s_axis_tvalid && s_axis_tready, state_q == ST_EXEC, "no exec")
  `TMI_ASSERT_IMPL(a_head_range, 1'b1, head_q <= HeadLast, "head beyond last tape cell")
  `TMI_ASSERT_IMPL(a_tape_wr_no_clear, tape_wr.en, !tape_busy, "cell write during tape clear")
  `TMI_ASSERT_IMPL(a_out_byte_ok, m_valid_q && obvalid_q, ostatus_q == STATUS_OK && !otaken_q, "bad")

endmodule
